// File: rtl/core/setops_pkg.sv
package setops_pkg;

  localparam int SET_DEPTH_DEF = 16;
  localparam int ELEM_W        = 32;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_A   = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_B   = 3'd2;
  localparam logic [OP_W-1:0] OP_UNION   = 3'd3;
  localparam logic [OP_W-1:0] OP_INTER   = 3'd4;
  localparam logic [OP_W-1:0] OP_DIFF    = 3'd5;
  localparam logic [OP_W-1:0] OP_SYMDIFF = 3'd6;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_MEMBER = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // how a scanned element is kept
  typedef enum logic [1:0] {
    FLT_ALL,
    FLT_IN,
    FLT_OUT
  } filt_t;

  typedef struct packed {
    logic  clear;
    logic  add_a;
    logic  add_b;
    logic  push_full;
    logic  scan_init;
    logic  idx_clear;
    logic  scan_step;
    logic  src_b;
    filt_t filt;
    logic  finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_done;
    logic full_a;
    logic full_b;
  } status_t;

endpackage

// File: rtl/core/setops_ctrl.sv
module setops_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [setops_pkg::OP_W-1:0]   operation,
  input  setops_pkg::status_t           status,
  output setops_pkg::cmd_t              cmd
);
  import setops_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN_A,
    S_SCAN_B,
    S_FINISH
  } state_t;

  state_t          state, state_next;
  logic [OP_W-1:0] op_q, op_q_next;
  logic            accept;

  assign in_ready = (state == S_IDLE) && status.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    cmd.filt   = FLT_ALL;
    state_next = state;
    op_q_next  = op_q;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_CLEAR: cmd.clear = 1'b1;
            OP_ADD_A: begin
              if (status.full_a) cmd.push_full = 1'b1;
              else cmd.add_a = 1'b1;
            end
            OP_ADD_B: begin
              if (status.full_b) cmd.push_full = 1'b1;
              else cmd.add_b = 1'b1;
            end
            OP_UNION, OP_INTER, OP_DIFF, OP_SYMDIFF: begin
              cmd.scan_init = 1'b1;
              op_q_next     = operation;
              state_next    = S_SCAN_A;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_A: begin
        cmd.src_b = 1'b0;
        case (op_q)
          OP_UNION: cmd.filt = FLT_ALL;
          OP_INTER: cmd.filt = FLT_IN;
          default:  cmd.filt = FLT_OUT;
        endcase
        if (status.scan_done) begin
          cmd.idx_clear = 1'b1;
          if (op_q inside {OP_UNION, OP_SYMDIFF}) state_next = S_SCAN_B;
          else state_next = S_FINISH;
        end else if (status.out_free) begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SCAN_B: begin
        cmd.src_b = 1'b1;
        cmd.filt  = FLT_OUT;
        if (status.scan_done) begin
          state_next = S_FINISH;
        end else if (status.out_free) begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op_q  <= OP_CLEAR;
    end else begin
      state <= state_next;
      op_q  <= op_q_next;
    end
  end

endmodule

// File: rtl/core/setops_dp.sv
module setops_dp #(
  parameter int DEPTH = setops_pkg::SET_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  setops_pkg::cmd_t                     cmd,
  output setops_pkg::status_t                  status,
  input  logic signed [setops_pkg::ELEM_W-1:0] element_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [setops_pkg::ELEM_W-1:0] result_value,
  output logic [setops_pkg::STATUS_W-1:0]      result_status,
  output logic                                 last_of_run
);
  import setops_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [ELEM_W-1:0] store_a [DEPTH];
  logic [ELEM_W-1:0] store_b [DEPTH];
  logic [CW-1:0]     count_a, count_b;
  logic [CW-1:0]     idx;
  logic [ELEM_W-1:0] pend;
  logic              pend_valid;

  logic [ELEM_W-1:0] elem;
  logic [CW-1:0]     src_count, oth_count;
  logic              hit, keep, out_free;
  logic              push;
  logic [ELEM_W-1:0] push_value;
  logic [STATUS_W-1:0] push_status;
  logic              push_last;

  assign out_free  = !out_valid || out_ready;
  assign src_count = cmd.src_b ? count_b : count_a;
  assign oth_count = cmd.src_b ? count_a : count_b;
  assign elem      = cmd.src_b ? store_b[idx[AW-1:0]] : store_a[idx[AW-1:0]];

  assign status.out_free  = out_free;
  assign status.scan_done = (idx == src_count);
  assign status.full_a    = (count_a == CW'(DEPTH));
  assign status.full_b    = (count_b == CW'(DEPTH));

  // parallel compare against every held entry of the other set
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < DEPTH; k++) begin
      if (CW'(k) < oth_count) begin
        if (cmd.src_b) hit = hit | (store_a[k] == elem);
        else hit = hit | (store_b[k] == elem);
      end
    end
  end

  always_comb begin
    case (cmd.filt)
      FLT_ALL: keep = 1'b1;
      FLT_IN:  keep = hit;
      FLT_OUT: keep = !hit;
      default: keep = 1'b0;
    endcase
  end

  // one element is held back so the last one can be marked
  always_comb begin
    push        = 1'b0;
    push_value  = pend;
    push_status = ST_MEMBER;
    push_last   = 1'b0;
    if (cmd.push_full) begin
      push        = 1'b1;
      push_value  = element_value;
      push_status = ST_FULL;
      push_last   = 1'b1;
    end else if (cmd.scan_step && keep && pend_valid) begin
      push = 1'b1;
    end else if (cmd.finish) begin
      push      = 1'b1;
      push_last = 1'b1;
      if (!pend_valid) begin
        push_value  = '0;
        push_status = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_a) store_a[count_a[AW-1:0]] <= element_value;
    if (cmd.add_b) store_b[count_b[AW-1:0]] <= element_value;
    if (cmd.scan_init || cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + 1'b1;
    end
    if (cmd.scan_step && keep) pend <= elem;
    if (push) begin
      result_value  <= push_value;
      result_status <= push_status;
      last_of_run   <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a    <= '0;
      count_b    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count_a <= '0;
        count_b <= '0;
      end else begin
        if (cmd.add_a) count_a <= count_a + 1'b1;
        if (cmd.add_b) count_b <= count_b + 1'b1;
      end
      if (cmd.scan_init || cmd.finish) begin
        pend_valid <= 1'b0;
      end else if (cmd.scan_step && keep) begin
        pend_valid <= 1'b1;
      end
      if (push) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/set_operations_engine.sv
// two stored integer sets, a and b, built by load requests and queried
// by set operation requests
// input channel: in_valid / in_ready with operation and element_value;
//   clear, add to a, add to b, union, intersection, a minus b,
//   symmetric difference; code 7 is taken and ignored
// output channel: out_valid / out_ready with result_value, result_status
//   and last_of_run, which marks the final result of one request
// a clear or a successful add gives no result; an add into a full set
//   gives one full-status result in the next cycle
// a query walks the source set one entry a cycle while the output is free,
//   comparing the entry against every held entry of the other set at once;
//   union and symmetric difference walk a and then b; results leave at up
//   to one per cycle, the last one pushed from the finish state after the
//   scan ends; an empty answer gives one empty-status result
// with no stall the next request can be taken once a query has finished,
//   and in the next cycle after a clear or an add
// requests are taken one at a time; in_ready is high only while no query
//   runs and the output register is free or being emptied
// a stalled receiver freezes the scan in place; nothing is dropped
// reset empties both sets and the output register

module set_operations_engine #(
  parameter int SET_DEPTH = setops_pkg::SET_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [setops_pkg::OP_W-1:0]          operation,
  input  logic signed [setops_pkg::ELEM_W-1:0] element_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [setops_pkg::ELEM_W-1:0] result_value,
  output logic [setops_pkg::STATUS_W-1:0]      result_status,
  output logic                                 last_of_run
);
  import setops_pkg::*;

  // command and status between the sequencer and the set storage
  cmd_t    cmd;
  status_t status;

  // sequencer: decodes requests and steps the scan phases
  setops_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  // storage, membership compare, hold-back stage and output register
  setops_dp #(
    .DEPTH (SET_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_value  (result_value),
    .result_status (result_status),
    .last_of_run   (last_of_run)
  );

endmodule
